// File: hw/rtl/first_fit_partition_allocator_top_defines.svh
// Assertion macros for the partition allocator.
`ifndef FIRST_FIT_PARTITION_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_PARTITION_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define FFPA_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define FFPA_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define FFPA_ASSERT(name, clk, rst_n, prop, msg)

`define FFPA_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

// File: hw/rtl/ffpa_pkg.sv
package ffpa_pkg;

  localparam int unsigned OwnerW  = 8;
  localparam int unsigned AmountW = 10;
  localparam int unsigned StatusW = 3;
  localparam int unsigned AddrW   = 9;

  localparam int unsigned MemUnits = 512;

  localparam logic OpAlloc   = 1'b0;
  localparam logic OpRelease = 1'b1;

  localparam logic [StatusW-1:0] StOk      = 3'd0;
  localparam logic [StatusW-1:0] StNoFit   = 3'd1;
  localparam logic [StatusW-1:0] StNoOwner = 3'd2;
  localparam logic [StatusW-1:0] StTooMuch = 3'd3;
  localparam logic [StatusW-1:0] StFull    = 3'd4;

endpackage

// File: hw/rtl/first_fit_partition_allocator_top.sv
// First-fit partition allocator. Each request word (tuser = operation, tdata = owner and
// amount) yields one result word (status and start address). The segment table sits in one
// synchronous memory of MAX_SEGMENTS entries; a request reads and checks it entry by entry up
// to the matching entry, reads and checks the following entry when a release frees a whole
// segment, then shifts entries one at a time, each read and then written, when a split
// inserts or a merge removes entries, and ends with a read that closes the shift, two
// write-back steps and a result step. Scan and shift together never cover more than the
// table; the memory has a single read and a single write port. The block returns to idle
// before it takes the next request, and the result step waits while an earlier result is
// still held at the output. One request is processed at a time; a new request is taken
// while a result waits at the output. No clearing pass runs after reset: entry 0 reads as
// one free segment over all memory until first written.
`include "first_fit_partition_allocator_top_defines.svh"

module first_fit_partition_allocator_top #(
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // owner [7:0], amount [17:8]
  input  logic [0:0]  s_axis_tuser,  // operation [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // status [2:0], start_address [11:3]
);

  localparam int unsigned AW = $clog2(ffpa_pkg::MemUnits);
  localparam int unsigned SW = $clog2(ffpa_pkg::MemUnits + 1);
  localparam int unsigned CW = (SW > ffpa_pkg::AmountW) ? SW : ffpa_pkg::AmountW;
  localparam int unsigned IW = $clog2(MAX_SEGMENTS);
  localparam int unsigned NW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned OW = ffpa_pkg::OwnerW;
  localparam int unsigned EW = AW + SW + OW + 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SC_RD  = 4'd1;
  localparam logic [3:0] S_SC_CHK = 4'd2;
  localparam logic [3:0] S_NX_RD  = 4'd3;
  localparam logic [3:0] S_NX_CHK = 4'd4;
  localparam logic [3:0] S_SH_RD  = 4'd5;
  localparam logic [3:0] S_SH_WR  = 4'd6;
  localparam logic [3:0] S_FIN_A  = 4'd7;
  localparam logic [3:0] S_FIN_B  = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  localparam logic [EW-1:0] ResetEnt = {1'b0, {OW{1'b0}}, SW'(ffpa_pkg::MemUnits), {AW{1'b0}}};

  function automatic logic [EW-1:0] pack_ent(logic [AW-1:0] st, logic [SW-1:0] sz,
                                             logic [OW-1:0] ow, logic us);
    return {us, ow, sz, st};
  endfunction

  logic [EW-1:0] mem_q [MAX_SEGMENTS];
  logic [EW-1:0] rd_q;
  logic          rd0_q;
  logic          init_q;

  logic [3:0]    state_q, state_d;
  logic          op_q;
  logic [OW-1:0] who_q;
  logic [ffpa_pkg::AmountW-1:0] amt_q;
  logic [NW-1:0] cnt_q, cnt_new_q;
  logic [NW-1:0] idx_q, j_q;
  logic [EW-1:0] cur_q, prv_q;
  logic [ffpa_pkg::StatusW-1:0] st_q;
  logic [AW-1:0] addr_q;
  logic          up_q, dn_q;
  logic [1:0]    k_q;
  logic          wa_en_q, wb_en_q;
  logic [IW-1:0] wa_idx_q, wb_idx_q;
  logic [EW-1:0] wa_dat_q, wb_dat_q;
  logic          m_valid_q;
  logic [15:0]   m_data_q;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [EW-1:0] wdata;
  logic [EW-1:0] rd_ent, e, p;

  logic [AW-1:0] e_start, p_start;
  logic [SW-1:0] e_size, p_size, n_size, amt_s;
  logic [OW-1:0] e_owner, p_owner;
  logic          e_used, p_used, n_used;
  logic [CW-1:0] amt_c, size_c;
  logic          match, p_free, n_free, full, need_next, last;

  logic [ffpa_pkg::StatusW-1:0] pl_st;
  logic [AW-1:0] pl_addr;
  logic          pl_up, pl_dn;
  logic [1:0]    pl_k;
  logic [NW-1:0] pl_j, pl_cnt;
  logic          pl_wa, pl_wb;
  logic [IW-1:0] pl_wa_idx, pl_wb_idx;
  logic [EW-1:0] pl_wa_dat, pl_wb_dat;
  logic [NW-1:0] f1;
  logic          sh_go;

  assign rd_ent = rd0_q ? ResetEnt : rd_q;
  assign e      = (state_q == S_NX_CHK) ? cur_q : rd_ent;
  assign p      = prv_q;
  assign {e_used, e_owner, e_size, e_start} = e;
  assign {p_used, p_owner, p_size, p_start} = p;
  assign n_used = rd_ent[EW-1];
  assign n_size = rd_ent[AW +: SW];
  assign amt_c  = CW'(amt_q);
  assign size_c = CW'(e_size);
  assign amt_s  = SW'(amt_q);
  assign f1     = idx_q + NW'(1);
  assign last   = (f1 == cnt_q);
  assign full   = (cnt_q == NW'(MAX_SEGMENTS));
  assign p_free = (idx_q != '0) && !p_used;
  assign n_free = (state_q == S_NX_CHK) && !n_used;
  assign match  = (op_q == ffpa_pkg::OpAlloc) ? (!e_used && amt_q != '0 && size_c >= amt_c)
                                              : (e_used && e_owner == who_q);

  always_comb begin
    pl_st     = ffpa_pkg::StOk;
    pl_addr   = e_start;
    pl_up     = 1'b0;
    pl_dn     = 1'b0;
    pl_k      = 2'd1;
    pl_j      = '0;
    pl_cnt    = cnt_q;
    pl_wa     = 1'b0;
    pl_wb     = 1'b0;
    pl_wa_idx = idx_q[IW-1:0];
    pl_wb_idx = idx_q[IW-1:0];
    pl_wa_dat = '0;
    pl_wb_dat = '0;
    need_next = 1'b0;
    if (op_q == ffpa_pkg::OpAlloc) begin
      if (size_c == amt_c) begin
        pl_wa     = 1'b1;
        pl_wa_dat = pack_ent(e_start, e_size, who_q, 1'b1);
      end else if (full) begin
        pl_st = ffpa_pkg::StFull;
      end else begin
        pl_up     = 1'b1;
        pl_j      = cnt_q - NW'(1);
        pl_cnt    = cnt_q + NW'(1);
        pl_wa     = 1'b1;
        pl_wa_idx = f1[IW-1:0];
        pl_wa_dat = pack_ent(e_start + AW'(amt_q), e_size - amt_s, '0, 1'b0);
        pl_wb     = 1'b1;
        pl_wb_dat = pack_ent(e_start, amt_s, who_q, 1'b1);
      end
    end else begin
      if (amt_q == '0 || amt_c > size_c) begin
        pl_st = ffpa_pkg::StTooMuch;
      end else if (amt_c == size_c) begin
        if (state_q == S_SC_CHK && !last) begin
          need_next = 1'b1;
        end else if (p_free && n_free) begin
          pl_wa     = 1'b1;
          pl_wa_idx = IW'(idx_q - NW'(1));
          pl_wa_dat = pack_ent(p_start, p_size + e_size + n_size, p_owner, 1'b0);
          pl_dn     = 1'b1;
          pl_k      = 2'd2;
          pl_j      = idx_q + NW'(2);
          pl_cnt    = cnt_q - NW'(2);
        end else if (p_free) begin
          pl_wa     = 1'b1;
          pl_wa_idx = IW'(idx_q - NW'(1));
          pl_wa_dat = pack_ent(p_start, p_size + e_size, p_owner, 1'b0);
          pl_dn     = 1'b1;
          pl_j      = f1;
          pl_cnt    = cnt_q - NW'(1);
        end else if (n_free) begin
          pl_wa     = 1'b1;
          pl_wa_dat = pack_ent(e_start, e_size + n_size, '0, 1'b0);
          pl_dn     = 1'b1;
          pl_j      = idx_q + NW'(2);
          pl_cnt    = cnt_q - NW'(1);
        end else begin
          pl_wa     = 1'b1;
          pl_wa_dat = pack_ent(e_start, e_size, '0, 1'b0);
        end
      end else if (p_free) begin
        pl_wa     = 1'b1;
        pl_wa_idx = IW'(idx_q - NW'(1));
        pl_wa_dat = pack_ent(p_start, p_size + amt_s, p_owner, 1'b0);
        pl_wb     = 1'b1;
        pl_wb_dat = pack_ent(e_start + AW'(amt_q), e_size - amt_s, who_q, 1'b1);
      end else if (full) begin
        pl_st = ffpa_pkg::StFull;
      end else begin
        pl_up     = 1'b1;
        pl_j      = cnt_q - NW'(1);
        pl_cnt    = cnt_q + NW'(1);
        pl_wa     = 1'b1;
        pl_wa_idx = f1[IW-1:0];
        pl_wa_dat = pack_ent(e_start + AW'(amt_q), e_size - amt_s, who_q, 1'b1);
        pl_wb     = 1'b1;
        pl_wb_dat = pack_ent(e_start, amt_s, '0, 1'b0);
      end
    end
  end

  assign sh_go = up_q ? (j_q > idx_q) : (dn_q && (j_q < cnt_q));

  always_comb begin
    we    = 1'b0;
    waddr = wa_idx_q;
    wdata = wa_dat_q;
    case (state_q)
      S_SH_WR: begin
        we    = 1'b1;
        waddr = up_q ? IW'(j_q + NW'(1)) : IW'(j_q - NW'(k_q));
        wdata = rd_ent;
      end
      S_FIN_A: begin
        we = wa_en_q;
      end
      S_FIN_B: begin
        we    = wb_en_q;
        waddr = wb_idx_q;
        wdata = wb_dat_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (state_q)
      S_NX_RD: raddr = f1[IW-1:0];
      S_SH_RD: raddr = j_q[IW-1:0];
      default: raddr = idx_q[IW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= 1'b1;
      rd0_q  <= 1'b0;
    end else begin
      rd0_q <= init_q && (raddr == '0) && !(we && waddr == '0);
      if (we && waddr == '0) begin
        init_q <= 1'b0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (s_axis_tvalid) state_d = S_SC_RD;
      S_SC_RD:  state_d = S_SC_CHK;
      S_SC_CHK: begin
        if (match) begin
          if (need_next) state_d = S_NX_RD;
          else if (pl_st != ffpa_pkg::StOk) state_d = S_DONE;
          else state_d = S_SH_RD;
        end else if (last) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SC_RD;
        end
      end
      S_NX_RD:  state_d = S_NX_CHK;
      S_NX_CHK: state_d = S_SH_RD;
      S_SH_RD:  state_d = sh_go ? S_SH_WR : S_FIN_A;
      S_SH_WR:  state_d = S_SH_RD;
      S_FIN_A:  state_d = S_FIN_B;
      S_FIN_B:  state_d = S_DONE;
      S_DONE:   if (!m_valid_q || m_axis_tready) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= NW'(1);
      m_valid_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          idx_q <= '0;
        end
        S_SC_CHK: begin
          if (!match) begin
            idx_q <= f1;
          end
        end
        S_FIN_B: begin
          cnt_q <= cnt_new_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        op_q  <= s_axis_tuser[0];
        who_q <= s_axis_tdata[7:0];
        amt_q <= s_axis_tdata[17:8];
        up_q  <= 1'b0;
        dn_q  <= 1'b0;
      end
      S_SC_CHK, S_NX_CHK: begin
        if (state_q == S_NX_CHK || match) begin
          cur_q     <= e;
          st_q      <= pl_st;
          addr_q    <= (pl_st == ffpa_pkg::StOk) ? pl_addr : '0;
          up_q      <= pl_up;
          dn_q      <= pl_dn;
          k_q       <= pl_k;
          j_q       <= pl_j;
          cnt_new_q <= pl_cnt;
          wa_en_q   <= pl_wa;
          wb_en_q   <= pl_wb;
          wa_idx_q  <= pl_wa_idx;
          wb_idx_q  <= pl_wb_idx;
          wa_dat_q  <= pl_wa_dat;
          wb_dat_q  <= pl_wb_dat;
        end else begin
          prv_q  <= e;
          st_q   <= (op_q == ffpa_pkg::OpAlloc) ? ffpa_pkg::StNoFit : ffpa_pkg::StNoOwner;
          addr_q <= '0;
        end
      end
      S_SH_WR: begin
        j_q <= up_q ? (j_q - NW'(1)) : (j_q + NW'(1));
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_data_q <= {4'b0, ffpa_pkg::AddrW'(addr_q), st_q};
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `FFPA_ASSERT(a_cnt_hold, clk_i, rst_ni, (state_q != S_FIN_B) |=> $stable(cnt_q), "segment count moved outside write-back")
  `FFPA_ASSERT(a_we_state, clk_i, rst_ni, we |-> (state_q == S_SH_WR || state_q == S_FIN_A || state_q == S_FIN_B), "table write outside shift or write-back")
  `FFPA_ASSERT_ALWAYS(a_err_addr, clk_i, (m_axis_tvalid && m_axis_tdata[2:0] != ffpa_pkg::StOk) |-> (m_axis_tdata[11:3] == '0), "nonzero address on error status")

endmodule
